// ===== sv/blud_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blud_pkg
// Shared types and codes of the byte-level UTF-8 token decoder.
// ----------------------------------------------------------------------------
package blud_pkg;

   // Error codes carried in a result.
   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_BAD_LEAD = 3'd1;
   localparam logic [2:0] ERR_BAD_CONT = 3'd2;
   localparam logic [2:0] ERR_TRUNC    = 3'd3;
   localparam logic [2:0] ERR_OVERLONG = 3'd4;
   localparam logic [2:0] ERR_SURR     = 3'd5;
   localparam logic [2:0] ERR_TOO_BIG  = 3'd6;
   localparam logic [2:0] ERR_NOT_BL   = 3'd7;

   // One input item.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } blud_req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] error;
      logic       out_last;
   } blud_rsp_type;

   // Decoder state carried from byte to byte.
   typedef struct packed {
      logic [20:0] partial_scalar;
      logic [1:0]  bytes_remaining;
      logic [1:0]  sequence_length;
      logic        pending_bad_cont;
      logic        dropping_rest;
   } blud_state_type;

endpackage

`default_nettype wire

// ===== sv/blud_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blud_step
// Combinational decode of one byte: next decoder state and optional result.
// ----------------------------------------------------------------------------
module blud_step (
   input  wire blud_pkg::blud_state_type state_cur,
   input  wire blud_pkg::blud_req_type   req,
   output blud_pkg::blud_state_type      state_nxt,
   output logic                          res_valid,
   output blud_pkg::blud_rsp_type        res
);

   logic [7:0]  b;
   logic        last;
   logic        is_cont;
   logic [20:0] part_upd;
   logic        pend_upd;
   logic [1:0]  rem_upd;
   logic [20:0] cp_fin;
   logic [1:0]  len_fin;
   logic [2:0]  fin_err;
   logic [7:0]  fin_byte;
   logic [7:0]  k;
   logic        do_emit;
   logic [2:0]  emit_err;
   logic [7:0]  emit_byte;

   assign b       = req.in_byte;
   assign last    = req.in_last;
   assign is_cont = (b[7:6] == 2'b10);

   // Continuation byte folded into the partial scalar.
   assign pend_upd = state_cur.pending_bad_cont | ~is_cont;
   assign part_upd = (!state_cur.pending_bad_cont && is_cont) ?
                     {state_cur.partial_scalar[14:0], b[5:0]} :
                     state_cur.partial_scalar;
   assign rem_upd  = state_cur.bytes_remaining - 2'd1;

   // Scalar that completes on this byte, if any.
   assign cp_fin  = (state_cur.bytes_remaining == 2'd0) ? {13'd0, b} : part_upd;
   assign len_fin = (state_cur.bytes_remaining == 2'd0) ? 2'd0 :
                    state_cur.sequence_length;
   assign k       = cp_fin[7:0];

   // Checks on a completed scalar, in order of precedence, then the unmap.
   always_comb begin
      fin_err  = blud_pkg::ERR_OK;
      fin_byte = 8'd0;
      if ((len_fin == 2'd2 && cp_fin < 21'h800) ||
          (len_fin == 2'd3 && cp_fin < 21'h10000)) begin
         fin_err = blud_pkg::ERR_OVERLONG;
      end else if (cp_fin >= 21'hD800 && cp_fin <= 21'hDFFF) begin
         fin_err = blud_pkg::ERR_SURR;
      end else if (cp_fin > 21'h10FFFF) begin
         fin_err = blud_pkg::ERR_TOO_BIG;
      end else if ((cp_fin >= 21'd33 && cp_fin <= 21'd126) ||
                   (cp_fin >= 21'd161 && cp_fin <= 21'd172) ||
                   (cp_fin >= 21'd174 && cp_fin <= 21'd255)) begin
         fin_byte = k;
      end else if (cp_fin >= 21'd256 && cp_fin <= 21'd323) begin
         if (k < 8'd33) begin
            fin_byte = k;
         end else if (k < 8'd67) begin
            fin_byte = k + 8'd94;
         end else begin
            fin_byte = 8'd173;
         end
      end else begin
         fin_err = blud_pkg::ERR_NOT_BL;
      end
   end

   // Sequence control for one byte.
   always_comb begin
      state_nxt = state_cur;
      do_emit   = 1'b0;
      emit_err  = blud_pkg::ERR_OK;
      emit_byte = 8'd0;
      if (state_cur.dropping_rest) begin
         // Discard bytes until the end of the token.
         if (last) begin
            state_nxt = '0;
         end
      end else if (state_cur.bytes_remaining == 2'd0) begin
         if (b <= 8'h7F) begin
            do_emit   = 1'b1;
            emit_err  = fin_err;
            emit_byte = fin_byte;
         end else if (b >= 8'hC2 && b <= 8'hF4) begin
            if (last) begin
               do_emit  = 1'b1;
               emit_err = blud_pkg::ERR_TRUNC;
            end else begin
               state_nxt.pending_bad_cont = 1'b0;
               if (b <= 8'hDF) begin
                  state_nxt.partial_scalar  = {16'd0, b[4:0]};
                  state_nxt.bytes_remaining = 2'd1;
                  state_nxt.sequence_length = 2'd1;
               end else if (b <= 8'hEF) begin
                  state_nxt.partial_scalar  = {17'd0, b[3:0]};
                  state_nxt.bytes_remaining = 2'd2;
                  state_nxt.sequence_length = 2'd2;
               end else begin
                  state_nxt.partial_scalar  = {18'd0, b[2:0]};
                  state_nxt.bytes_remaining = 2'd3;
                  state_nxt.sequence_length = 2'd3;
               end
            end
         end else begin
            do_emit  = 1'b1;
            emit_err = blud_pkg::ERR_BAD_LEAD;
         end
      end else if (rem_upd != 2'd0) begin
         if (last) begin
            do_emit  = 1'b1;
            emit_err = blud_pkg::ERR_TRUNC;
         end else begin
            state_nxt.partial_scalar   = part_upd;
            state_nxt.pending_bad_cont = pend_upd;
            state_nxt.bytes_remaining  = rem_upd;
         end
      end else if (pend_upd) begin
         do_emit  = 1'b1;
         emit_err = blud_pkg::ERR_BAD_CONT;
      end else begin
         do_emit   = 1'b1;
         emit_err  = fin_err;
         emit_byte = fin_byte;
      end

      // A result always closes the current sequence.
      if (do_emit) begin
         state_nxt.partial_scalar   = '0;
         state_nxt.bytes_remaining  = 2'd0;
         state_nxt.sequence_length  = 2'd0;
         state_nxt.pending_bad_cont = 1'b0;
         state_nxt.dropping_rest    = (emit_err != blud_pkg::ERR_OK) && !last;
      end
   end

   // Result fields.
   assign res_valid    = do_emit;
   assign res.error    = emit_err;
   assign res.out_byte = (emit_err == blud_pkg::ERR_OK) ? emit_byte : 8'd0;
   assign res.out_last = (emit_err == blud_pkg::ERR_OK) ? last : 1'b1;

endmodule

`default_nettype wire

// ===== sv/bytelevel_utf8_token_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bytelevel_utf8_token_decoder
// Strict UTF-8 decoder that maps byte-level token scalars back to raw bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one byte of an encoded token per transfer, with
//   in_last on the token's final byte. The rsp channel returns zero or one
//   result per byte: a recovered raw byte, or an error code that ends the
//   token (bytes after it are dropped up to the one with in_last).
//   Each result is registered into the output register or the skid register.
//   Throughput: one byte per cycle while req_ready is high; the whole
//   per-byte decode sits between the decoder state and the result register.
//   Stall: results go to an output register backed by a one-entry skid
//   register, so a byte is still taken while one result waits; req_ready
//   drops only while the skid register is occupied.
//   Reset: synchronous reset clears the sequence state and empties both
//   result registers; req_ready is high once reset has emptied the skid.
// ----------------------------------------------------------------------------
module bytelevel_utf8_token_decoder (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire blud_pkg::blud_req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output blud_pkg::blud_rsp_type rsp_data
);

   blud_pkg::blud_state_type state_ff, state_in, state_step;
   blud_pkg::blud_rsp_type   res, out_ff, out_in, skid_ff, skid_in;
   logic                     res_valid;
   logic                     out_vld_ff, out_vld_in;
   logic                     skid_vld_ff, skid_vld_in;
   logic                     req_xfer;
   logic                     new_res;

   assign req_ready = !skid_vld_ff;
   assign req_xfer  = req_valid && req_ready;

   blud_step u_step (
      .state_cur (state_ff),
      .req       (req_data),
      .state_nxt (state_step),
      .res_valid (res_valid),
      .res       (res)
   );

   assign state_in = req_xfer ? state_step : state_ff;
   assign new_res  = req_xfer && res_valid;

   // Output register with skid entry.
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = res;
            out_vld_in = new_res;
         end
      end else if (new_res) begin
         skid_in     = res;
         skid_vld_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== dv/bytelevel_utf8_token_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bytelevel_utf8_token_decoder_tb
// Self-checking bench for the byte-level UTF-8 token decoder. A short run of
// directed tokens hits every error code and both ends of the byte map. It is
// followed by random tokens: mostly well-formed sequences, plus some overlong,
// surrogate and out-of-range forms, damaged tokens and raw noise. A predictor
// computes the expected result of every accepted byte. A monitor checks each
// result transfer field by field; both sides stall at random up to the last third.
// ----------------------------------------------------------------------------
module bytelevel_utf8_token_decoder_tb;

   localparam int RANDOM_BYTES = 1920;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   blud_pkg::blud_req_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   blud_pkg::blud_rsp_type rsp_data;

   // Predictor copy of the decoder state.
   logic [20:0] dec_partial   = '0;
   logic [1:0]  dec_remaining = '0;
   logic [1:0]  dec_length    = '0;
   logic        dec_bad_cont  = 1'b0;
   logic        dec_dropping  = 1'b0;

   blud_pkg::blud_req_type byte_q[$];
   blud_pkg::blud_rsp_type result_q[$];
   logic [7:0]             tok[$];

   int send_idle_pct  = 22;
   int recv_stall_pct = 48;
   int accepted_cnt   = 0;
   int mismatch_cnt   = 0;

   bytelevel_utf8_token_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Ends the token's sequence and builds its result.
   function automatic blud_pkg::blud_rsp_type close_token(logic [7:0] raw,
                                                          logic [2:0] err,
                                                          logic last);
      blud_pkg::blud_rsp_type r;
      dec_partial   = '0;
      dec_remaining = '0;
      dec_length    = '0;
      dec_bad_cont  = 1'b0;
      if (err != blud_pkg::ERR_OK) begin
         dec_dropping = ~last;
         r.out_byte = 8'h00;
         r.error    = err;
         r.out_last = 1'b1;
      end else begin
         r.out_byte = raw;
         r.error    = blud_pkg::ERR_OK;
         r.out_last = last;
      end
      return r;
   endfunction

   // Range checks on a completed scalar, then the map back to a raw byte.
   function automatic blud_pkg::blud_rsp_type complete_scalar(logic [20:0] cp,
                                                              logic [1:0] len,
                                                              logic last);
      int unsigned v;
      v = 32'(cp);
      if ((len == 2'd2 && v < 'h800) || (len == 2'd3 && v < 'h10000))
         return close_token(8'h00, blud_pkg::ERR_OVERLONG, last);
      if (v >= 'hD800 && v <= 'hDFFF)
         return close_token(8'h00, blud_pkg::ERR_SURR, last);
      if (v > 'h10FFFF)
         return close_token(8'h00, blud_pkg::ERR_TOO_BIG, last);
      if ((v >= 33 && v <= 126) || (v >= 161 && v <= 172) || (v >= 174 && v <= 255))
         return close_token(v[7:0], blud_pkg::ERR_OK, last);
      if (v < 256 || v > 323)
         return close_token(8'h00, blud_pkg::ERR_NOT_BL, last);
      v = v - 256;
      if (v < 33)
         return close_token(v[7:0], blud_pkg::ERR_OK, last);
      if (v < 67)
         return close_token(v[7:0] + 8'd94, blud_pkg::ERR_OK, last);
      return close_token(8'd173, blud_pkg::ERR_OK, last);
   endfunction

   // Advances the predictor by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_byte(blud_pkg::blud_req_type item,
                                      output blud_pkg::blud_rsp_type r);
      logic [7:0]  b;
      logic        last;
      logic [1:0]  count;
      logic [20:0] bits;
      b    = item.in_byte;
      last = item.in_last;
      r    = '0;
      if (dec_dropping) begin
         if (last) begin
            dec_partial   = '0;
            dec_remaining = '0;
            dec_length    = '0;
            dec_bad_cont  = 1'b0;
            dec_dropping  = 1'b0;
         end
         return 1'b0;
      end
      if (dec_remaining == 2'd0) begin
         if (b <= 8'h7F) begin
            r = complete_scalar({13'd0, b}, 2'd0, last);
            return 1'b1;
         end
         if (b >= 8'hC2 && b <= 8'hDF) begin
            count = 2'd1;
            bits  = {16'd0, b[4:0]};
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            count = 2'd2;
            bits  = {17'd0, b[3:0]};
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            count = 2'd3;
            bits  = {18'd0, b[2:0]};
         end else begin
            r = close_token(8'h00, blud_pkg::ERR_BAD_LEAD, last);
            return 1'b1;
         end
         if (last) begin
            r = close_token(8'h00, blud_pkg::ERR_TRUNC, last);
            return 1'b1;
         end
         dec_partial   = bits;
         dec_remaining = count;
         dec_length    = count;
         dec_bad_cont  = 1'b0;
         return 1'b0;
      end
      // After the first bad continuation the remaining bytes are only counted.
      if (!dec_bad_cont) begin
         if (b[7:6] != 2'b10)
            dec_bad_cont = 1'b1;
         else
            dec_partial = {dec_partial[14:0], b[5:0]};
      end
      dec_remaining = dec_remaining - 2'd1;
      if (dec_remaining != 2'd0) begin
         if (last) begin
            r = close_token(8'h00, blud_pkg::ERR_TRUNC, last);
            return 1'b1;
         end
         return 1'b0;
      end
      if (dec_bad_cont) begin
         r = close_token(8'h00, blud_pkg::ERR_BAD_CONT, last);
         return 1'b1;
      end
      r = complete_scalar(dec_partial, dec_length, last);
      return 1'b1;
   endfunction

   task automatic put_byte(logic [7:0] b, logic last);
      blud_pkg::blud_req_type item;
      item.in_byte = b;
      item.in_last = last;
      byte_q.insert(byte_q.size(), item);
   endtask

   // Appends one byte to the token buffer.
   task automatic add_tok_byte(logic [7:0] b);
      tok.insert(tok.size(), b);
   endtask

   // Appends the UTF-8 form of a scalar of the given length to the token buffer.
   task automatic encode_scalar(logic [20:0] cp, int len);
      case (len)
         1: add_tok_byte({1'b0, cp[6:0]});
         2: begin
            add_tok_byte({3'b110, cp[10:6]});
            add_tok_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_tok_byte({4'b1110, cp[15:12]});
            add_tok_byte({2'b10, cp[11:6]});
            add_tok_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_tok_byte({5'b11110, cp[20:18]});
            add_tok_byte({2'b10, cp[17:12]});
            add_tok_byte({2'b10, cp[11:6]});
            add_tok_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Builds one random token and queues its bytes, last flag on the final one.
   task automatic add_random_token();
      int          scalars;
      int          kind;
      int          pick;
      int          keep;
      logic [7:0]  raw;
      logic [20:0] cp;
      tok.delete();
      // Raw noise with random last flags inside the token.
      if ($urandom_range(99) < 5) begin
         keep = $urandom_range(1, 5);
         for (int i = 0; i < keep; i++)
            put_byte(8'($urandom_range(255)),
                     (i == keep - 1) ? 1'b1 : 1'($urandom_range(1)));
         return;
      end
      scalars = $urandom_range(1, 4);
      for (int i = 0; i < scalars; i++) begin
         kind = $urandom_range(99);
         pick = $urandom_range(4);
         if (kind < 70) begin
            // Well-formed scalar that stands for a random raw byte.
            raw = 8'($urandom_range(255));
            if ((raw >= 33 && raw <= 126) || (raw >= 161 && raw <= 172) || raw >= 174)
               cp = 21'(raw);
            else if (raw <= 32)
               cp = 21'(256 + raw);
            else if (raw == 173)
               cp = 21'd323;
            else
               cp = 21'(raw + 162);
            encode_scalar(cp, (cp < 'h80) ? 1 : 2);
         end else if (kind < 82) begin
            // Shortest form of a scalar from a random range.
            case (pick)
               0: begin
                  cp = 21'($urandom_range('h7F));
                  encode_scalar(cp, 1);
               end
               1: begin
                  cp = 21'($urandom_range('h7FF, 'h80));
                  encode_scalar(cp, 2);
               end
               2: begin
                  cp = 21'($urandom_range('hFFFF, 'h800));
                  encode_scalar(cp, 3);
               end
               3: begin
                  cp = 21'($urandom_range('hDFFF, 'hD800));
                  encode_scalar(cp, 3);
               end
               default: begin
                  cp = 21'($urandom_range('h13FFFF, 'h10000));
                  encode_scalar(cp, 4);
               end
            endcase
         end else if (kind < 90) begin
            // Overlong forms: a small scalar spread over more bytes than needed.
            if (pick < 1) begin
               cp = 21'($urandom_range('h7F));
               encode_scalar(cp, 2);
            end else if (pick < 3) begin
               cp = 21'($urandom_range('h7FF));
               encode_scalar(cp, 3);
            end else begin
               cp = 21'($urandom_range('hFFFF));
               encode_scalar(cp, 4);
            end
         end else begin
            add_tok_byte(8'($urandom_range(255)));
         end
      end
      // Damage a few tokens: one byte overwritten, or the tail cut off.
      keep = tok.size();
      kind = $urandom_range(99);
      if (kind < 8)
         tok[$urandom_range(tok.size() - 1)] = 8'($urandom_range(255));
      else if (kind < 14 && keep > 1)
         keep = $urandom_range(1, keep - 1);
      for (int i = 0; i < keep; i++)
         put_byte(tok[i], i == keep - 1);
   endtask

   // Driver: predicts each accepted byte and presents the next pending one.
   always @(posedge clock) begin : drive
      blud_pkg::blud_rsp_type predicted;
      logic                   next_valid;
      blud_pkg::blud_req_type next_data;
      if (reset) begin
         req_valid     <= 1'b0;
         dec_partial   = '0;
         dec_remaining = '0;
         dec_length    = '0;
         dec_bad_cont  = 1'b0;
         dec_dropping  = 1'b0;
      end else begin
         next_valid = req_valid;
         next_data  = req_data;
         if (req_valid && req_ready) begin
            accepted_cnt++;
            if (decode_byte(req_data, predicted))
               result_q.insert(result_q.size(), predicted);
            next_valid = 1'b0;
         end
         if (!next_valid && byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_valid = 1'b1;
            next_data  = byte_q.pop_front();
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin : observe
      blud_pkg::blud_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_REPORTS)
                  $display("unexpected result: byte %02h error %0d last %0b",
                           rsp_data.out_byte, rsp_data.error, rsp_data.out_last);
            end else begin
               want = result_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.error !== want.error ||
                   rsp_data.out_last !== want.out_last) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= MAX_REPORTS)
                     $display({"mismatch: expected byte %02h error %0d last %0b, ",
                               "got byte %02h error %0d last %0b"},
                              want.out_byte, want.error, want.out_last,
                              rsp_data.out_byte, rsp_data.error, rsp_data.out_last);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : stimulus
      int total;
      // Directed tokens: ASCII, a two-scalar token at both ends of the upper map.
      put_byte(8'h41, 1'b1);
      put_byte(8'hC4, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(8'hC5, 1'b0);
      put_byte(8'h83, 1'b1);
      put_byte(8'hC3, 1'b0);
      put_byte(8'hBF, 1'b1);
      // Not ByteLevel on a byte that is not last, so the rest is dropped.
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b1);
      // Bad lead bytes at the low end of each rejected range.
      put_byte(8'h80, 1'b1);
      put_byte(8'hF5, 1'b1);
      // Overlong, surrogate and too-large forms.
      put_byte(8'hE0, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(8'h80, 1'b1);
      put_byte(8'hED, 1'b0);
      put_byte(8'hA0, 1'b0);
      put_byte(8'h80, 1'b1);
      put_byte(8'hF4, 1'b0);
      put_byte(8'h90, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(8'h80, 1'b1);
      // Truncation, a held bad continuation, and truncation outranking it.
      put_byte(8'hE2, 1'b0);
      put_byte(8'h82, 1'b1);
      put_byte(8'hE2, 1'b0);
      put_byte(8'h41, 1'b0);
      put_byte(8'h41, 1'b1);
      put_byte(8'hE2, 1'b0);
      put_byte(8'h41, 1'b1);
      total = byte_q.size() + RANDOM_BYTES;
      while (byte_q.size() < total)
         add_random_token();
      total = byte_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Idle pattern changes by thirds of the run.
      while (accepted_cnt < total / 3)
         @(posedge clock);
      send_idle_pct  = 48;
      recv_stall_pct = 22;
      while (accepted_cnt < (2 * total) / 3)
         @(posedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      while (byte_q.size() != 0 || req_valid)
         @(posedge clock);
      while (result_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Timeout guard.
   initial begin : watchdog
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
